### design/tes_pkg.sv
// Shared types, widths and ramp tables for the triangle elevation shader.
package tes_pkg;

  localparam int ELEV_W        = 16;
  localparam int TILE_W        = 6;
  localparam int MAX_TILE      = 32;
  localparam int COORD_W       = 5;
  localparam int S_W           = 6;
  localparam int SS_W          = 11;
  localparam int WGT_W         = 14;
  localparam int PROD_W        = ELEV_W + WGT_W;
  localparam int NUM_W         = 32;
  localparam int QBITS         = 15;
  localparam int DIV_W         = SS_W + QBITS;
  localparam int BITS_PER_STEP = 3;
  localparam int DIV_STEPS     = QBITS / BITS_PER_STEP;
  localparam int COLOUR_W      = 32;
  localparam int RAMP_N        = 16;

  localparam int W_STAGES = 2;
  localparam int D_STAGES = 1 + DIV_STEPS;
  localparam int NSTAGE   = W_STAGES + D_STAGES + 1;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int PADDR_W    = 3;

  localparam logic [TILE_W-1:0] TILE_RESET = 6'd4;

  // register index, taken from paddr[2]
  localparam logic REG_TILE_SIZE = 1'b0;

  localparam logic signed [ELEV_W-1:0] ELEV_MAX = 16'sh7FFF;
  localparam logic signed [ELEV_W-1:0] ELEV_MIN = 16'sh8000;

  localparam logic signed [ELEV_W-1:0] RAMP_LIMIT [RAMP_N] = '{
    -16'sd1000, -16'sd500, 16'sd0, 16'sd50, 16'sd250, 16'sd500, 16'sd750, 16'sd1000,
    16'sd1250, 16'sd1500, 16'sd1750, 16'sd2000, 16'sd2250, 16'sd2500, 16'sd2750,
    16'sd3000
  };

  localparam logic [COLOUR_W-1:0] RAMP_COLOUR [RAMP_N+1] = '{
    32'h000070FF, 32'h000088FF, 32'h0000A0FF, 32'h009000FF, 32'h009000FF,
    32'h10A008FF, 32'h18B010FF, 32'h20C018FF, 32'h30D018FF, 32'h40D818FF,
    32'h50E020FF, 32'h68C828FF, 32'h80B028FF, 32'h989828FF, 32'hB08030FF,
    32'hC07030FF, 32'hF0F0F0FF
  };

  typedef struct packed {
    logic signed [PROD_W-1:0] left;
    logic signed [PROD_W-1:0] right;
    logic signed [PROD_W-1:0] tip;
  } prod_t;

  typedef struct packed {
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             ovf;
  } quot_t;

endpackage

### design/tes_weight.sv
// Barycentric weight stage and elevation-by-weight products.
module tes_weight (
  input  logic                                clk,
  input  logic [tes_pkg::W_STAGES-1:0]        en,
  input  logic [tes_pkg::S_W-1:0]             s,
  input  logic [tes_pkg::SS_W-1:0]            ss,
  input  logic signed [tes_pkg::ELEV_W-1:0]   elev_tip,
  input  logic signed [tes_pkg::ELEV_W-1:0]   elev_left,
  input  logic signed [tes_pkg::ELEV_W-1:0]   elev_right,
  input  logic [tes_pkg::COORD_W-1:0]         pixel_col,
  input  logic [tes_pkg::COORD_W-1:0]         pixel_row,
  output tes_pkg::prod_t                      prod
);

  logic [tes_pkg::S_W-2:0]     half;
  logic [tes_pkg::COORD_W:0]   col_p1;
  logic [tes_pkg::COORD_W:0]   row_p1;
  logic [10:0]                 tip_u;
  logic [11:0]                 right_a;
  logic [10:0]                 right_b;
  logic signed [tes_pkg::WGT_W-1:0] w_tip_c, w_right_c, w_left_c;

  logic signed [tes_pkg::WGT_W-1:0]  w_tip, w_right, w_left;
  logic signed [tes_pkg::ELEV_W-1:0] et, el, er;

  always_comb begin
    half      = s[tes_pkg::S_W-1:1];
    col_p1    = {1'b0, pixel_col} + 6'd1;
    row_p1    = {1'b0, pixel_row} + 6'd1;
    tip_u     = {6'd0, pixel_row} * {5'd0, s};
    right_a   = {6'd0, col_p1} * {6'd0, s};
    right_b   = {6'd0, half} * {5'd0, row_p1};
    w_tip_c   = $signed({3'b000, tip_u});
    w_right_c = $signed({2'b00, right_a}) - $signed({3'b000, right_b});
    w_left_c  = $signed({3'b000, ss}) - w_tip_c - w_right_c;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w_tip   <= w_tip_c;
      w_right <= w_right_c;
      w_left  <= w_left_c;
      et      <= elev_tip;
      el      <= elev_left;
      er      <= elev_right;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod.left  <= el * w_left;
      prod.right <= er * w_right;
      prod.tip   <= et * w_tip;
    end
  end

endmodule

### design/tes_divide.sv
// Blend sum, magnitude/overflow check and pipelined restoring divide by S*S.
module tes_divide (
  input  logic                           clk,
  input  logic [tes_pkg::D_STAGES-1:0]   en,
  input  logic [tes_pkg::SS_W-1:0]       ss,
  input  tes_pkg::prod_t                 prod,
  output tes_pkg::quot_t                 quot
);

  logic signed [tes_pkg::NUM_W-1:0] num;
  logic [tes_pkg::NUM_W-1:0]        nabs;
  logic [tes_pkg::NUM_W-1:0]        limit;

  logic [tes_pkg::DIV_W-1:0] rem0;
  logic                      neg0, ovf0;

  logic [tes_pkg::DIV_W-1:0] rem_q  [tes_pkg::DIV_STEPS];
  logic [tes_pkg::QBITS-1:0] quo_q  [tes_pkg::DIV_STEPS];
  logic                      neg_q  [tes_pkg::DIV_STEPS];
  logic                      ovf_q  [tes_pkg::DIV_STEPS];
  logic [tes_pkg::DIV_W-1:0] rem_next [tes_pkg::DIV_STEPS];
  logic [tes_pkg::QBITS-1:0] quo_next [tes_pkg::DIV_STEPS];

  always_comb begin
    num   = prod.left + prod.right + prod.tip;
    nabs  = num[tes_pkg::NUM_W-1] ? tes_pkg::NUM_W'(-num) : tes_pkg::NUM_W'(num);
    // anything at or past 32768*S*S saturates either way
    limit = {6'd0, ss, 15'd0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem0 <= nabs[tes_pkg::DIV_W-1:0];
      neg0 <= num[tes_pkg::NUM_W-1];
      ovf0 <= (nabs >= limit);
    end
  end

  // three quotient bits per stage, most significant first
  always_comb begin
    logic [tes_pkg::DIV_W-1:0] r;
    logic [tes_pkg::DIV_W-1:0] d;
    logic [tes_pkg::QBITS-1:0] q;
    int                        pos;
    for (int j = 0; j < tes_pkg::DIV_STEPS; j++) begin
      if (j == 0) begin
        r = rem0;
        q = '0;
      end else begin
        r = rem_q[j-1];
        q = quo_q[j-1];
      end
      for (int b = 0; b < tes_pkg::BITS_PER_STEP; b++) begin
        pos = tes_pkg::QBITS - 1 - j * tes_pkg::BITS_PER_STEP - b;
        d   = {{tes_pkg::QBITS{1'b0}}, ss} << pos;
        if (r >= d) begin
          r      = r - d;
          q[pos] = 1'b1;
        end
      end
      rem_next[j] = r;
      quo_next[j] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < tes_pkg::DIV_STEPS; j++) begin
      if (en[j+1]) begin
        rem_q[j] <= rem_next[j];
        quo_q[j] <= quo_next[j];
        if (j == 0) begin
          neg_q[j] <= neg0;
          ovf_q[j] <= ovf0;
        end else begin
          neg_q[j] <= neg_q[j-1];
          ovf_q[j] <= ovf_q[j-1];
        end
      end
    end
  end

  assign quot.quo = quo_q[tes_pkg::DIV_STEPS-1];
  assign quot.neg = neg_q[tes_pkg::DIV_STEPS-1];
  assign quot.ovf = ovf_q[tes_pkg::DIV_STEPS-1];

endmodule

### design/tes_ramp.sv
// Sign, saturation and colour ramp lookup into the output register.
module tes_ramp (
  input  logic                               clk,
  input  logic                               en,
  input  tes_pkg::quot_t                     quot,
  output logic [tes_pkg::COLOUR_W-1:0]       colour_rgba,
  output logic signed [tes_pkg::ELEV_W-1:0]  shade_elevation
);

  logic signed [tes_pkg::ELEV_W-1:0] e;
  logic [tes_pkg::COLOUR_W-1:0]      colour;

  always_comb begin
    if (quot.ovf) begin
      e = quot.neg ? tes_pkg::ELEV_MIN : tes_pkg::ELEV_MAX;
    end else if (quot.neg) begin
      e = -$signed({1'b0, quot.quo});
    end else begin
      e = $signed({1'b0, quot.quo});
    end
    // scan from the top threshold down so the lowest match wins
    colour = tes_pkg::RAMP_COLOUR[tes_pkg::RAMP_N];
    for (int i = tes_pkg::RAMP_N - 1; i >= 0; i--) begin
      if (e < tes_pkg::RAMP_LIMIT[i]) begin
        colour = tes_pkg::RAMP_COLOUR[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      colour_rgba     <= colour;
      shade_elevation <= e;
    end
  end

endmodule

### design/triangle_elevation_shade.sv
// Top level: config register, stage valid/advance control and the shading pipeline.
//
// Shades one triangle-tile pixel per clock when the output is not stalled: every cycle a
// beat may enter, and each result passes nine register stages (weights, products, blend
// sum, five divider stages, ramp/output register). The depth is set by the divide by S*S,
// done as a pipelined restoring divider that resolves three quotient bits per stage. Each
// stage advances when it is empty or the stage after it moves, so s_tready drops only when
// every stage holds a pixel and the output beat is stalled. Write the tile edge register
// only while no pixel is in flight; the new size applies from the next beat.
module triangle_elevation_shade (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: elev_tip[15:0], elev_left[31:16], elev_right[47:32],
  //          pixel_col[52:48], pixel_row[57:53], zero pad [63:58]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tes_pkg::IN_DATA_W-1:0]     s_tdata,
  // m_tdata: colour_rgba[31:0], shade_elevation[47:32]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tes_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tes_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [tes_pkg::TILE_W-1:0] tile;
  logic [tes_pkg::SS_W-1:0]   ss;
  logic [tes_pkg::TILE_W-1:0] ts_c;
  logic [tes_pkg::S_W-1:0]    s;
  logic                       cfg_wr;

  logic [tes_pkg::NSTAGE-1:0] v;
  logic [tes_pkg::NSTAGE-1:0] adv;

  tes_pkg::prod_t  prod;
  tes_pkg::quot_t  quot;
  logic [tes_pkg::COLOUR_W-1:0]      colour_rgba;
  logic signed [tes_pkg::ELEV_W-1:0] shade_elevation;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tes_pkg::REG_TILE_SIZE);
  assign prdata = {26'd0, tile};

  always_comb begin
    if (tile == '0) begin
      ts_c = 6'd1;
    end else if (tile > tes_pkg::TILE_W'(tes_pkg::MAX_TILE)) begin
      ts_c = tes_pkg::TILE_W'(tes_pkg::MAX_TILE);
    end else begin
      ts_c = tile;
    end
    s  = ts_c + 6'd1;
    ss = {5'd0, s} * {5'd0, s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile <= tes_pkg::TILE_RESET;
    end else begin
      if (cfg_wr) begin
        tile <= pwdata[tes_pkg::TILE_W-1:0];
      end
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[tes_pkg::NSTAGE-1] = !v[tes_pkg::NSTAGE-1] || m_tready;
    for (int k = tes_pkg::NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < tes_pkg::NSTAGE; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = v[tes_pkg::NSTAGE-1];
  assign m_tdata  = {shade_elevation, colour_rgba};

  tes_weight u_weight (
    .clk        (clk),
    .en         (adv[tes_pkg::W_STAGES-1:0]),
    .s          (s),
    .ss         (ss),
    .elev_tip   (s_tdata[15:0]),
    .elev_left  (s_tdata[31:16]),
    .elev_right (s_tdata[47:32]),
    .pixel_col  (s_tdata[52:48]),
    .pixel_row  (s_tdata[57:53]),
    .prod       (prod)
  );

  tes_divide u_divide (
    .clk  (clk),
    .en   (adv[tes_pkg::W_STAGES+tes_pkg::D_STAGES-1:tes_pkg::W_STAGES]),
    .ss   (ss),
    .prod (prod),
    .quot (quot)
  );

  tes_ramp u_ramp (
    .clk             (clk),
    .en              (adv[tes_pkg::NSTAGE-1]),
    .quot            (quot),
    .colour_rgba     (colour_rgba),
    .shade_elevation (shade_elevation)
  );

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[0])
    else $error("accepted beat did not enter the first stage");

  a_tile_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> tile == $past(pwdata[tes_pkg::TILE_W-1:0]))
    else $error("tile edge write lost");

  a_negative_colour: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && shade_elevation < 0 |-> colour_rgba[31:16] == 16'h0000)
    else $error("negative elevation mapped outside the water colours");
`endif

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the triangle elevation shader: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_PAUSE  = 14;
  localparam int LONG_STALL   = 120;
  localparam int IDLE_PCT     = 13;
  localparam int PHASE_BEATS  = 128;
  localparam int MAX_REPORTS  = 10;

  localparam logic [tes_pkg::PADDR_W-1:0] ADDR_TILE_SIZE = 3'd0;
  localparam logic [tes_pkg::PADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

  localparam int EDGE_ELEV [12] = '{-1001, -1000, -501, -500, -1, 0, 49, 50, 250, 499,
                                    2999, 3000};

  localparam longint RAMP_EDGE [16] = '{
    -1000, -500, 0, 50, 250, 500, 750, 1000,
    1250, 1500, 1750, 2000, 2250, 2500, 2750, 3000
  };

  localparam logic [tes_pkg::COLOUR_W-1:0] RAMP_RGBA [17] = '{
    32'h000070FF, 32'h000088FF, 32'h0000A0FF, 32'h009000FF, 32'h009000FF,
    32'h10A008FF, 32'h18B010FF, 32'h20C018FF, 32'h30D018FF, 32'h40D818FF,
    32'h50E020FF, 32'h68C828FF, 32'h80B028FF, 32'h989828FF, 32'hB08030FF,
    32'hC07030FF, 32'hF0F0F0FF
  };

  typedef struct packed {
    logic [tes_pkg::COLOUR_W-1:0]      colour;
    logic signed [tes_pkg::ELEV_W-1:0] elev;
  } shade_t;

  class shade_scoreboard;
    logic [tes_pkg::TILE_W-1:0] tile_reg;
    shade_t                     expected_shades[$];
    int                         fails;

    function new();
      tile_reg = tes_pkg::TILE_RESET;
      fails    = 0;
    endfunction

    function void note_config(int index, logic [31:0] value);
      if (index == 0) tile_reg = value[tes_pkg::TILE_W-1:0];
    endfunction

    function shade_t predict_shade(logic [tes_pkg::IN_DATA_W-1:0] beat);
      longint et, el, er, col, row, ts, s, ss, wt, wr, wl, num, e;
      shade_t r;
      et  = longint'($signed(beat[15:0]));
      el  = longint'($signed(beat[31:16]));
      er  = longint'($signed(beat[47:32]));
      col = longint'(beat[52:48]);
      row = longint'(beat[57:53]);
      ts  = longint'(tile_reg);
      if (ts < 1) ts = 1;
      if (ts > tes_pkg::MAX_TILE) ts = tes_pkg::MAX_TILE;
      s   = ts + 1;
      ss  = s * s;
      wt  = row * s;
      wr  = s * (col + 1) - (s / 2) * (row + 1);
      wl  = ss - wt - wr;
      num = el * wl + er * wr + et * wt;
      // signed divide truncates toward zero
      e = num / ss;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      r.elev   = e[tes_pkg::ELEV_W-1:0];
      r.colour = RAMP_RGBA[16];
      for (int i = 15; i >= 0; i--) begin
        if (e < RAMP_EDGE[i]) r.colour = RAMP_RGBA[i];
      end
      return r;
    endfunction

    function void note_pixel(logic [tes_pkg::IN_DATA_W-1:0] beat);
      expected_shades.push_back(predict_shade(beat));
    endfunction

    function void check_shade(logic [tes_pkg::OUT_DATA_W-1:0] beat);
      shade_t want;
      if (expected_shades.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("unexpected output beat %h", beat);
        return;
      end
      want = expected_shades.pop_front();
      if (beat[31:0] !== want.colour || beat[47:32] !== want.elev) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("mismatch: colour exp %h got %h, elevation exp %0d got %0d",
                   want.colour, beat[31:0], want.elev, $signed(beat[47:32]));
      end
    endfunction

    function int pending();
      return expected_shades.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [tes_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [tes_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tes_pkg::PADDR_W-1:0]    paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  shade_scoreboard sb = new();
  bit idle_on  = 1'b1;
  bit stall_go = 1'b0;
  int stall_left = 0;

  triangle_elevation_shade i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int cycle = 0; cycle < LIMIT_CYCLES; cycle++) @(posedge clk);
    $display("triangle_elevation_shade regression: fail");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (stall_go) begin
        stall_go   = 1'b0;
        stall_left = LONG_STALL - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_shade(m_tdata);
  end

  function automatic logic [tes_pkg::IN_DATA_W-1:0] pack_pixel(logic [15:0] tip,
                                                               logic [15:0] left,
                                                               logic [15:0] right,
                                                               logic [4:0] col,
                                                               logic [4:0] row);
    return {6'b0, row, col, right, left, tip};
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_pixel(logic [tes_pkg::IN_DATA_W-1:0] beat);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(beat);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [tes_pkg::PADDR_W-1:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_config(int'(addr) / 4, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for every shade to return, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] tile, int beats, int stall_at, int pause_at);
    int eff, mode, pick;
    logic [15:0] ev [3];
    logic [4:0] col, row;
    drain();
    apb_write(ADDR_TILE_SIZE, tile);
    repeat (2) @(negedge clk);
    eff = int'(tile[5:0]);
    if (eff < 1) eff = 1;
    if (eff > tes_pkg::MAX_TILE) eff = tes_pkg::MAX_TILE;
    for (int n = 0; n < beats; n++) begin
      if (n == stall_at) stall_go = 1'b1;
      if (n == pause_at) begin
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      mode = $urandom_range(99);
      col  = 5'($urandom_range(eff - 1));
      row  = 5'($urandom_range(eff - 1));
      for (int k = 0; k < 3; k++) ev[k] = 16'(int'($urandom_range(6000)) - 2000);
      if (mode < 15) begin
        // each vertex lands exactly on a ramp edge or one off either side
        pick = $urandom_range(15);
        for (int k = 0; k < 3; k++)
          ev[k] = 16'(RAMP_EDGE[pick] + longint'($urandom_range(2)) - 1);
      end else if (mode < 30) begin
        for (int k = 0; k < 3; k++) ev[k] = 16'($urandom);
      end else if (mode < 40) begin
        for (int k = 0; k < 3; k++) ev[k] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        col = 5'($urandom);
        row = 5'($urandom);
      end else if (mode < 55) begin
        for (int k = 0; k < 3; k++) ev[k] = 16'($urandom);
        col = 5'($urandom);
        row = 5'($urandom);
      end
      send_pixel(pack_pixel(ev[0], ev[1], ev[2], col, row));
    end
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats at the reset tile size
    send_pixel(pack_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 5'd0, 5'd0));
    send_pixel(pack_pixel(16'h8000, 16'h8000, 16'h8000, 5'd0, 5'd0));
    send_pixel(pack_pixel(16'h7FFF, 16'h8000, 16'h8000, 5'd3, 5'd0));
    send_pixel(pack_pixel(16'h8000, 16'h7FFF, 16'h7FFF, 5'd3, 5'd3));
    send_pixel(pack_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 5'd31, 5'd31));
    send_pixel(pack_pixel(16'h8000, 16'h8000, 16'h8000, 5'd31, 5'd0));
    send_pixel(pack_pixel(16'd1000, -16'sd1000, 16'd2000, 5'd31, 5'd31));
    send_pixel(pack_pixel(16'd0, 16'd0, 16'd0, 5'd0, 5'd31));
    for (int i = 0; i < 12; i++)
      send_pixel(pack_pixel(16'(EDGE_ELEV[i]), 16'(EDGE_ELEV[i]), 16'(EDGE_ELEV[i]),
                            5'd2, 5'd1));

    // tile size sweep, extremes and out-of-range values included
    run_phase(32'd1, PHASE_BEATS, -1, -1);
    run_phase(32'd0, PHASE_BEATS, -1, -1);
    idle_on = 1'b0;
    run_phase(32'd32, PHASE_BEATS, -1, -1);
    idle_on = 1'b1;
    run_phase(32'd63, PHASE_BEATS, 20, -1);
    run_phase(32'd33, PHASE_BEATS, -1, 60);
    drain();
    // write to an unmapped index must leave the tile edge register alone
    apb_write(ADDR_UNMAPPED, $urandom_range(63));
    run_phase(32'd2, PHASE_BEATS, -1, -1);
    run_phase(32'd17, PHASE_BEATS, -1, -1);
    run_phase(32'($urandom_range(31, 3)), PHASE_BEATS, 40, -1);
    run_phase($urandom, PHASE_BEATS, -1, -1);
    run_phase(32'd4, PHASE_BEATS, -1, -1);

    drain();
    if (sb.fails == 0) begin
      $display("triangle_elevation_shade regression: pass");
    end else begin
      $display("triangle_elevation_shade regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
design/tes_pkg.sv
design/tes_weight.sv
design/tes_divide.sv
design/tes_ramp.sv
design/triangle_elevation_shade.sv
tb/sv/testbench.sv
